FILE: rtl/dtps_pkg.sv
package dtps_pkg;

    // Fixed field widths.
    localparam int DIST_W = 8;
    localparam int GAIN_W = 16;
    localparam int FREQ_W = 16;
    localparam int SPAN_W = 3;
    localparam int AVG_W  = 24;
    localparam int MANT_W = 31;

    // Default size of the fractional exponent table.
    localparam int FRAC_TABLE_BITS_DEF = 6;

    // Quotient bits produced by the divider.
    localparam int DIV_STEPS = 16;

    // Register reset values.
    localparam logic [GAIN_W-1:0] GAIN_RST    = 16'd9830;
    localparam logic [DIST_W-1:0] DMIN_RST    = 8'd40;
    localparam logic [DIST_W-1:0] DMAX_RST    = 8'd200;
    localparam logic [FREQ_W-1:0] LOWF_RST    = 16'd1760;
    localparam logic [SPAN_W-1:0] SPAN_RST    = 3'd4;
    localparam logic [AVG_W-1:0]  SMOOTH_RST  = 24'h640000;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_GAIN = 3'd0;
    localparam logic [2:0] REG_DMIN = 3'd1;
    localparam logic [2:0] REG_DMAX = 3'd2;
    localparam logic [2:0] REG_LOWF = 3'd3;
    localparam logic [2:0] REG_SPAN = 3'd4;

    // Datapath operations selected by the control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT,
        OP_EMA_MUL,
        OP_EMA_UPD,
        OP_XSEL,
        OP_DIV,
        OP_SPAN,
        OP_EXP_MUL,
        OP_EXP_RND,
        OP_FMUL,
        OP_FOUT
    } t_op;

    // Sequencing conditions.
    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_WAIT_IN,
        C_LOOP,
        C_DIRECT,
        C_WAIT_OUT
    } t_cond;

    typedef logic [3:0] t_addr;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_addr target;
    } t_uword;

    // Program addresses.
    localparam t_addr A_WAIT    = 4'd0;
    localparam t_addr A_EMA_MUL = 4'd1;
    localparam t_addr A_EMA_UPD = 4'd2;
    localparam t_addr A_XSEL    = 4'd3;
    localparam t_addr A_DIV     = 4'd4;
    localparam t_addr A_SPAN    = 4'd5;
    localparam t_addr A_EXP_MUL = 4'd6;
    localparam t_addr A_EXP_RND = 4'd7;
    localparam t_addr A_FMUL    = 4'd8;
    localparam t_addr A_FOUT    = 4'd9;

    // Control store: one word per program step.
    function automatic t_uword ucode(input t_addr addr);
        t_uword w;
        unique case (addr)
            A_WAIT:    w = '{op: OP_WAIT,    cond: C_WAIT_IN,  target: A_WAIT};
            A_EMA_MUL: w = '{op: OP_EMA_MUL, cond: C_NEXT,     target: A_WAIT};
            A_EMA_UPD: w = '{op: OP_EMA_UPD, cond: C_NEXT,     target: A_WAIT};
            A_XSEL:    w = '{op: OP_XSEL,    cond: C_DIRECT,   target: A_SPAN};
            A_DIV:     w = '{op: OP_DIV,     cond: C_LOOP,     target: A_DIV};
            A_SPAN:    w = '{op: OP_SPAN,    cond: C_NEXT,     target: A_WAIT};
            A_EXP_MUL: w = '{op: OP_EXP_MUL, cond: C_NEXT,     target: A_WAIT};
            A_EXP_RND: w = '{op: OP_EXP_RND, cond: C_LOOP,     target: A_EXP_MUL};
            A_FMUL:    w = '{op: OP_FMUL,    cond: C_NEXT,     target: A_WAIT};
            A_FOUT:    w = '{op: OP_FOUT,    cond: C_WAIT_OUT, target: A_WAIT};
            default:   w = '{op: OP_NOP,     cond: C_JUMP,     target: A_WAIT};
        endcase
        return w;
    endfunction

    // Floor square root of a 64-bit value, digit by digit.
    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_v;
        rem   = n;
        res   = '0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // Root 2^(2^-(j+1)) in Q1.30, each root the square root of the one before.
    function automatic logic [MANT_W-1:0] root_q30(input int j);
        logic [63:0] r;
        r = isqrt64(64'h2000_0000_0000_0000);
        for (int i = 1; i < 16; i++) begin
            if (i <= j) begin
                r = isqrt64(r << 30);
            end
        end
        return r[MANT_W-1:0];
    endfunction

endpackage

FILE: rtl/dtps_if.sv
// Input channel: one raw distance per item.
interface dtps_in_if;
    logic                         valid;
    logic                         ready;
    logic [dtps_pkg::DIST_W-1:0]  distance_mm;

    modport source (output valid, output distance_mm, input ready);
    modport sink   (input valid, input distance_mm, output ready);
endinterface

// Output channel: tone frequency and smoothed distance per item.
interface dtps_out_if;
    logic                         valid;
    logic                         ready;
    logic [dtps_pkg::FREQ_W-1:0]  freq_sixteenths;
    logic [15:0]                  filtered_distance;

    modport source (output valid, output freq_sixteenths, output filtered_distance,
                    input ready);
    modport sink   (input valid, input freq_sixteenths, input filtered_distance,
                    output ready);
endinterface

FILE: rtl/distance_to_pitch_smoother_core.sv
// Each item runs through the clamp, the moving-average update, the normalisation by a
// 16-step bit-serial divider (bypassed when the average is clamped to an end of the
// range), the exponent loop and the final scale, the multiplies all on one shared
// multiplier. A new input is accepted only after the result enters the output register.
// Reset (synchronous, active low) restores the register defaults, sets the average to
// 100.0 mm and empties the output register.
module distance_to_pitch_smoother_core #(
    parameter int FRAC_TABLE_BITS = dtps_pkg::FRAC_TABLE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dtps_in_if.sink           i_in,
    dtps_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IDX_W = $clog2(FRAC_TABLE_BITS);
    localparam int CNT_W = ($clog2(FRAC_TABLE_BITS) > 4) ? $clog2(FRAC_TABLE_BITS) : 4;
    localparam int PROD_W = 2 * dtps_pkg::MANT_W;
    localparam int SH_W = 55;

    // Configuration registers.
    logic [15:0] r_gain;
    logic [7:0]  r_dmin;
    logic [7:0]  r_dmax;
    logic [15:0] r_lowf;
    logic [2:0]  r_span;

    // Sequencer and datapath registers.
    dtps_pkg::t_addr r_step, n_step;
    logic [7:0]  r_d, n_d;
    logic [23:0] r_s, n_s;
    logic        r_up, n_up;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [16:0] r_x, n_x;
    logic [7:0]  r_rem, n_rem;
    logic [15:0] r_quo, n_quo;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [2:0]  r_k, n_k;
    logic [FRAC_TABLE_BITS-1:0] r_idx, n_idx;
    logic [30:0] r_mant, n_mant;
    logic [15:0] r_freq, n_freq;
    logic [15:0] r_filt, n_filt;
    logic        r_out_valid, n_out_valid;

    dtps_pkg::t_uword w_uw;
    logic        w_in_acc;
    logic        w_out_load;
    logic        w_cfg_wr;
    logic [7:0]  w_dlo;
    logic [7:0]  w_dcl;
    logic [23:0] w_target;
    logic [23:0] w_mag;
    logic [24:0] w_delta;
    logic [23:0] w_dminx;
    logic [23:0] w_dmaxx;
    logic [7:0]  w_div;
    logic        w_inv;
    logic        w_direct;
    logic [23:0] w_num;
    logic [8:0]  w_trial;
    logic        w_ge;
    logic [18:0] w_e;
    logic [IDX_W-1:0] w_root_idx;
    logic [30:0] w_root [FRAC_TABLE_BITS];
    logic [30:0] w_mul_a;
    logic [30:0] w_mul_b;
    logic [PROD_W-1:0] w_mul;
    logic [PROD_W-1:0] w_rnd;
    logic [SH_W-1:0] w_shl;
    logic [SH_W-1:0] w_fr;
    logic [24:0] w_fq;

    // Root constants of the fractional exponent, folded at elaboration.
    for (genvar g = 0; g < FRAC_TABLE_BITS; g++) begin : g_root
        assign w_root[g] = dtps_pkg::root_q30(g);
    end

    // Handshakes.
    assign w_uw       = dtps_pkg::ucode(r_step);
    assign i_in.ready = (r_step == dtps_pkg::A_WAIT);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_load = !r_out_valid || o_out.ready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;

    // Input clamp: raise to the lower bound first, then cap at the upper one.
    assign w_dlo = (i_in.distance_mm < r_dmin) ? r_dmin : i_in.distance_mm;
    assign w_dcl = (w_dlo > r_dmax) ? r_dmax : w_dlo;

    // Moving average terms.
    assign w_target = {r_d, 16'h0000};
    assign w_mag    = (w_target >= r_s) ? (w_target - r_s) : (r_s - w_target);
    assign w_delta  = 25'((r_prod[39:0] + 40'd32768) >> 16);

    // Normalisation: end cases bypass the divider.
    assign w_dminx  = {r_dmin, 16'h0000};
    assign w_dmaxx  = {r_dmax, 16'h0000};
    assign w_div    = r_dmax - r_dmin;
    assign w_inv    = (r_dmax <= r_dmin);
    assign w_direct = w_inv || (r_s <= w_dminx) || (r_s >= w_dmaxx);
    assign w_num    = r_s - w_dminx;

    // One restoring divider step.
    assign w_trial = {r_rem, r_quo[15]};
    assign w_ge    = (w_trial >= {1'b0, w_div});

    // Exponent split and root selection.
    assign w_e        = 19'(r_span) * 19'(r_x);
    assign w_root_idx = IDX_W'(FRAC_TABLE_BITS - 1) - r_cnt[IDX_W-1:0];

    // Shared multiplier operand selection.
    always_comb begin
        unique case (w_uw.op)
            dtps_pkg::OP_EMA_MUL: begin
                w_mul_a = 31'(r_gain);
                w_mul_b = 31'(w_mag);
            end
            dtps_pkg::OP_EXP_MUL: begin
                w_mul_a = r_mant;
                w_mul_b = w_root[w_root_idx];
            end
            dtps_pkg::OP_FMUL: begin
                w_mul_a = 31'(r_lowf);
                w_mul_b = r_mant;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul = {31'h0, w_mul_a} * {31'h0, w_mul_b};
    assign w_rnd = r_prod + PROD_W'(64'd1 << 29);

    // Final scale by the octave count and rounding; the output step saturates.
    assign w_shl = SH_W'(r_prod[46:0]) << r_k;
    assign w_fr  = w_shl + SH_W'(64'd1 << 29);
    assign w_fq  = w_fr[54:30];

    // Next-address logic of the sequencer.
    always_comb begin
        unique case (w_uw.cond)
            dtps_pkg::C_NEXT:     n_step = r_step + 4'd1;
            dtps_pkg::C_JUMP:     n_step = w_uw.target;
            dtps_pkg::C_WAIT_IN:  n_step = w_in_acc ? r_step + 4'd1 : r_step;
            dtps_pkg::C_LOOP:     n_step = (r_cnt != '0) ? w_uw.target : r_step + 4'd1;
            dtps_pkg::C_DIRECT:   n_step = w_direct ? w_uw.target : r_step + 4'd1;
            dtps_pkg::C_WAIT_OUT: n_step = w_out_load ? w_uw.target : r_step;
            default:              n_step = dtps_pkg::A_WAIT;
        endcase
    end

    // Datapath actions of the current control word.
    always_comb begin
        n_d         = r_d;
        n_s         = r_s;
        n_up        = r_up;
        n_prod      = r_prod;
        n_x         = r_x;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_idx       = r_idx;
        n_mant      = r_mant;
        n_freq      = r_freq;
        n_filt      = r_filt;
        n_out_valid = r_out_valid && !o_out.ready;
        unique case (w_uw.op)
            dtps_pkg::OP_WAIT: begin
                if (w_in_acc) begin
                    n_d = w_dcl;
                end
            end
            dtps_pkg::OP_EMA_MUL: begin
                n_up   = (w_target >= r_s);
                n_prod = w_mul;
            end
            dtps_pkg::OP_EMA_UPD: begin
                n_s = r_up ? (r_s + w_delta[23:0]) : (r_s - w_delta[23:0]);
            end
            dtps_pkg::OP_XSEL: begin
                n_rem = w_num[23:16];
                n_quo = w_num[15:0];
                n_cnt = CNT_W'(dtps_pkg::DIV_STEPS - 1);
                if (w_inv || (r_s <= w_dminx)) begin
                    n_x = 17'h00000;
                end else begin
                    n_x = 17'h10000;
                end
            end
            dtps_pkg::OP_DIV: begin
                n_rem = w_ge ? 8'(w_trial - {1'b0, w_div}) : w_trial[7:0];
                n_quo = {r_quo[14:0], w_ge};
                n_x   = {1'b0, r_quo[14:0], w_ge};
                n_cnt = r_cnt - CNT_W'(1);
            end
            dtps_pkg::OP_SPAN: begin
                n_k    = w_e[18:16];
                n_idx  = w_e[15 -: FRAC_TABLE_BITS];
                n_mant = 31'h4000_0000;
                n_cnt  = CNT_W'(FRAC_TABLE_BITS - 1);
            end
            dtps_pkg::OP_EXP_MUL: begin
                if (r_idx[FRAC_TABLE_BITS-1]) begin
                    n_prod = w_mul;
                end else begin
                    n_prod = {1'b0, r_mant, 30'h0};
                end
            end
            dtps_pkg::OP_EXP_RND: begin
                n_mant = w_rnd[60:30];
                n_idx  = r_idx << 1;
                n_cnt  = r_cnt - CNT_W'(1);
            end
            dtps_pkg::OP_FMUL: begin
                n_prod = w_mul;
            end
            dtps_pkg::OP_FOUT: begin
                if (w_out_load) begin
                    n_freq      = (|w_fq[24:16]) ? 16'hFFFF : w_fq[15:0];
                    n_filt      = r_s[23:8];
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers, including the average, which reset restores.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= dtps_pkg::A_WAIT;
            r_out_valid <= 1'b0;
            r_s         <= dtps_pkg::SMOOTH_RST;
            r_gain      <= dtps_pkg::GAIN_RST;
            r_dmin      <= dtps_pkg::DMIN_RST;
            r_dmax      <= dtps_pkg::DMAX_RST;
            r_lowf      <= dtps_pkg::LOWF_RST;
            r_span      <= dtps_pkg::SPAN_RST;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_s         <= n_s;
            if (w_cfg_wr) begin
                unique case (paddr[4:2])
                    dtps_pkg::REG_GAIN: r_gain <= pwdata[15:0];
                    dtps_pkg::REG_DMIN: r_dmin <= pwdata[7:0];
                    dtps_pkg::REG_DMAX: r_dmax <= pwdata[7:0];
                    dtps_pkg::REG_LOWF: r_lowf <= pwdata[15:0];
                    dtps_pkg::REG_SPAN: r_span <= pwdata[2:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_d    <= n_d;
        r_up   <= n_up;
        r_prod <= n_prod;
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_k    <= n_k;
        r_idx  <= n_idx;
        r_mant <= n_mant;
        r_freq <= n_freq;
        r_filt <= n_filt;
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[4:2])
            dtps_pkg::REG_GAIN: prdata = {16'h0000, r_gain};
            dtps_pkg::REG_DMIN: prdata = {24'h000000, r_dmin};
            dtps_pkg::REG_DMAX: prdata = {24'h000000, r_dmax};
            dtps_pkg::REG_LOWF: prdata = {16'h0000, r_lowf};
            dtps_pkg::REG_SPAN: prdata = {29'h0, r_span};
            default:            prdata = 32'h0;
        endcase
    end

    assign pready                  = 1'b1;
    assign o_out.valid             = r_out_valid;
    assign o_out.freq_sixteenths   = r_freq;
    assign o_out.filtered_distance = r_filt;

`ifndef SYNTHESIS
    // The program counter never leaves the program.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= dtps_pkg::A_FOUT)
        else $error("sequencer left the program");

    // The partial remainder stays below the divisor throughout the division.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == dtps_pkg::A_DIV |-> r_rem < w_div)
        else $error("divider remainder reached the divisor");

    // An upward update never overshoots the target.
    a_ema_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == dtps_pkg::A_EMA_UPD && r_up
        |=> r_s >= $past(r_s) && r_s <= $past(w_target))
        else $error("average overshot upwards");

    // A downward update never undershoots the target.
    a_ema_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == dtps_pkg::A_EMA_UPD && !r_up
        |=> r_s <= $past(r_s) && r_s >= $past(w_target))
        else $error("average overshot downwards");

    // The mantissa stays in [1, 2) while the roots are applied.
    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == dtps_pkg::A_EXP_MUL |-> r_mant[30])
        else $error("exponent mantissa out of range");
`endif

endmodule
